FILE: hw/rtl/imubc_pkg.sv
package imubc_pkg;

	localparam int AXES = 3;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_STILL_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STILL_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 2'd2;

	// reset values, thresholds are kept squared
	localparam logic [15:0] STILL_MIN_RST = 16'd14746;
	localparam logic [15:0] STILL_MAX_RST = 16'd21299;
	localparam logic [14:0] GRAVITY_RST = 15'd16384;
	localparam logic [31:0] STILL_MIN_SQ_RST = 32'(STILL_MIN_RST) * 32'(STILL_MIN_RST);
	localparam logic [31:0] STILL_MAX_SQ_RST = 32'(STILL_MAX_RST) * 32'(STILL_MAX_RST);

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] out_accel_x;
		logic signed [15:0] out_accel_y;
		logic signed [15:0] out_accel_z;
		logic signed [15:0] out_rate_x;
		logic signed [15:0] out_rate_y;
		logic signed [15:0] out_rate_z;
		logic               corrected;
	} result_t;

	typedef struct packed {
		logic [31:0] min_sq;
		logic [31:0] max_sq;
		logic [14:0] gravity;
	} cfg_t;

	typedef struct packed {
		logic accum;
		logic complete;
	} bias_ctl_t;

	typedef struct packed {
		logic                  cal;
		logic                  ready;
		logic                  full;
		logic [AXES-1:0][16:0] accel_bias;
		logic [AXES-1:0][15:0] rate_bias;
	} bias_stat_t;

endpackage

FILE: hw/rtl/imubc_cfg.sv
module imubc_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [imubc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [imubc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output imubc_pkg::cfg_t                       cfg
);

	logic [31:0] wdata_sq;
	logic [31:0] min_sq_q;
	logic [31:0] max_sq_q;
	logic [14:0] gravity_q;

	// thresholds are squared once on write so the sample path only compares
	assign wdata_sq = 32'(cfg_wdata) * 32'(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sq_q <= imubc_pkg::STILL_MIN_SQ_RST;
			max_sq_q <= imubc_pkg::STILL_MAX_SQ_RST;
			gravity_q <= imubc_pkg::GRAVITY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				imubc_pkg::REG_STILL_MIN: min_sq_q <= wdata_sq;
				imubc_pkg::REG_STILL_MAX: max_sq_q <= wdata_sq;
				imubc_pkg::REG_GRAVITY: gravity_q <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	assign cfg.min_sq = min_sq_q;
	assign cfg.max_sq = max_sq_q;
	assign cfg.gravity = gravity_q;

endmodule

FILE: hw/rtl/imubc_bias.sv
module imubc_bias #(
	parameter int NUM_SAMPLES = 400
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  imubc_pkg::sample_t      sample,
	input  imubc_pkg::bias_ctl_t    ctl,
	input  logic [14:0]             gravity,
	output imubc_pkg::bias_stat_t   stat
);

	localparam int LANES = 2 * imubc_pkg::AXES;
	localparam int CNT_W = $clog2(NUM_SAMPLES + 1);
	localparam int SUM_W = 16 + $clog2(NUM_SAMPLES);
	localparam int SHIFT = SUM_W + $clog2(NUM_SAMPLES);
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W = SUM_W + RECIP_W;
	localparam int QUO_W = PROD_W - SHIFT;
	// rounded-up reciprocal, exact floor division for any magnitude below 2^SUM_W
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << SHIFT) + 64'(NUM_SAMPLES) - 64'd1) / 64'(NUM_SAMPLES);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

	logic signed [15:0]       smp [LANES];
	logic signed [SUM_W-1:0]  sum_q [LANES];
	logic [CNT_W-1:0]         count_q;
	logic                     cal_q;
	logic                     ready_q;
	logic [14:0]              grav_q;
	logic [PROD_W-1:0]        prod_q [LANES];
	logic                     neg_q [LANES];
	logic signed [16:0]       bias_q [LANES];
	logic [SUM_W-1:0]         mag [LANES];
	logic [QUO_W-1:0]         quo [LANES];
	logic signed [16:0]       qs [LANES];
	logic signed [16:0]       bias_next [LANES];
	logic                     full;

	assign smp[0] = sample.accel_x;
	assign smp[1] = sample.accel_y;
	assign smp[2] = sample.accel_z;
	assign smp[3] = sample.rate_x;
	assign smp[4] = sample.rate_y;
	assign smp[5] = sample.rate_z;

	assign full = (count_q == CNT_W'(NUM_SAMPLES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cal_q <= 1'b0;
			ready_q <= 1'b0;
			for (int i = 0; i < LANES; i++) begin
				sum_q[i] <= '0;
			end
		end else begin
			if (ctl.accum) begin
				count_q <= count_q + 1'b1;
				for (int i = 0; i < LANES; i++) begin
					sum_q[i] <= sum_q[i] + SUM_W'(smp[i]);
				end
			end
			if (ctl.complete) begin
				cal_q <= 1'b1;
			end
			// sums are frozen once full; ready follows cal after the divide pipe settles
			ready_q <= cal_q;
		end
	end

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			mag[i] = sum_q[i][SUM_W-1] ? SUM_W'(-sum_q[i]) : SUM_W'(sum_q[i]);
			quo[i] = prod_q[i][PROD_W-1:SHIFT];
			qs[i] = neg_q[i] ? -$signed(17'(quo[i])) : $signed(17'(quo[i]));
			bias_next[i] = (i == 2) ? qs[i] - $signed({2'b00, grav_q}) : qs[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.complete) begin
			grav_q <= gravity;
		end
		for (int i = 0; i < LANES; i++) begin
			prod_q[i] <= PROD_W'(mag[i]) * PROD_W'(RECIP);
			neg_q[i] <= sum_q[i][SUM_W-1];
			if (!ready_q) begin
				bias_q[i] <= bias_next[i];
			end
		end
	end

	always_comb begin
		stat.cal = cal_q;
		stat.ready = ready_q;
		stat.full = full;
		for (int i = 0; i < imubc_pkg::AXES; i++) begin
			stat.accel_bias[i] = bias_q[i];
			stat.rate_bias[i] = bias_q[i + imubc_pkg::AXES][15:0];
		end
	end

endmodule

FILE: hw/rtl/imu_bias_calibration_core.sv
// six-axis static bias calibration
// sample channel: sample_valid / sample_stall carry one raw accel+gyro item;
// an item is taken on a clock edge with sample_valid high and sample_stall low
// result channel: result_valid / result_stall carry one result item for every
// sample item, in order; result.corrected tells raw from bias-corrected data
// configuration: cfg_we, cfg_index, cfg_wdata write the still thresholds and
// the gravity count; the user must write them only while no item is in flight;
// the block itself does not enforce this
// throughput: one item per cycle while the receiver does not stall; the only
// other exception is the item right after the calibrating sample, held while
// the bias divider (reciprocal multiply) settles
// reset: uncalibrated, sums and still count cleared, registers at defaults,
// both pipeline stages empty
// a stalled receiver holds the result register; one more item is taken into
// the input stage, then sample_stall rises until the result moves on
module imu_bias_calibration_core #(
	parameter int NUM_SAMPLES = 400
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [imubc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [imubc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  imubc_pkg::sample_t                   sample,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output imubc_pkg::result_t                   result
);

	imubc_pkg::cfg_t        cfg;
	imubc_pkg::bias_ctl_t   ctl;
	imubc_pkg::bias_stat_t  stat;

	logic                   valid_s1;
	imubc_pkg::sample_t     data_s1;
	logic [30:0]            sq_s1 [imubc_pkg::AXES];
	logic signed [31:0]     sq_full [imubc_pkg::AXES];
	logic                   result_valid_q;
	imubc_pkg::result_t     result_q;
	imubc_pkg::result_t     res_next;
	logic [31:0]            mag2;
	logic                   still;
	logic                   out_free;
	logic                   hold;
	logic                   advance;
	logic                   take;
	logic signed [15:0]     raw [2 * imubc_pkg::AXES];
	logic signed [15:0]     fix [2 * imubc_pkg::AXES];

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		if (v > 18'sd32767) begin
			return 16'sh7fff;
		end else if (v < -18'sd32768) begin
			return -16'sh8000;
		end
		return v[15:0];
	endfunction

	imubc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	imubc_bias #(
		.NUM_SAMPLES (NUM_SAMPLES)
	) u_bias (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (data_s1),
		.ctl     (ctl),
		.gravity (cfg.gravity),
		.stat    (stat)
	);

	// squares are taken on the way into the input register
	assign sq_full[0] = 32'(sample.accel_x) * 32'(sample.accel_x);
	assign sq_full[1] = 32'(sample.accel_y) * 32'(sample.accel_y);
	assign sq_full[2] = 32'(sample.accel_z) * 32'(sample.accel_z);

	assign out_free = !result_valid_q || !result_stall;
	assign hold = stat.cal && !stat.ready;
	assign advance = valid_s1 && out_free && !hold;
	assign sample_stall = valid_s1 && !advance;
	assign take = sample_valid && !sample_stall;

	assign mag2 = 32'(sq_s1[0]) + 32'(sq_s1[1]) + 32'(sq_s1[2]);
	assign still = (mag2 >= cfg.min_sq) && (mag2 <= cfg.max_sq);

	assign ctl.accum = advance && !stat.cal && still && !stat.full;
	assign ctl.complete = advance && !stat.cal && still && stat.full;

	assign raw[0] = data_s1.accel_x;
	assign raw[1] = data_s1.accel_y;
	assign raw[2] = data_s1.accel_z;
	assign raw[3] = data_s1.rate_x;
	assign raw[4] = data_s1.rate_y;
	assign raw[5] = data_s1.rate_z;

	always_comb begin
		for (int i = 0; i < imubc_pkg::AXES; i++) begin
			fix[i] = sat16(18'(raw[i]) - 18'($signed(stat.accel_bias[i])));
			fix[i + imubc_pkg::AXES] = sat16(18'(raw[i + imubc_pkg::AXES])
				- 18'($signed(stat.rate_bias[i])));
		end
		res_next.out_accel_x = stat.cal ? fix[0] : raw[0];
		res_next.out_accel_y = stat.cal ? fix[1] : raw[1];
		res_next.out_accel_z = stat.cal ? fix[2] : raw[2];
		res_next.out_rate_x = stat.cal ? fix[3] : raw[3];
		res_next.out_rate_y = stat.cal ? fix[4] : raw[4];
		res_next.out_rate_z = stat.cal ? fix[5] : raw[5];
		res_next.corrected = stat.cal;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= sample;
			for (int i = 0; i < imubc_pkg::AXES; i++) begin
				sq_s1[i] <= sq_full[i][30:0];
			end
		end
		if (advance) begin
			result_q <= res_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	a_complete_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.complete |-> stat.full && !stat.cal)
		else $error("calibration completed before still count was full");

	a_bias_settles: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stat.cal) |=> stat.ready)
		else $error("bias not ready one cycle after calibration");

	a_corrected_uses_bias: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.corrected |-> stat.ready)
		else $error("corrected item sent before bias was ready");

	a_hold_blocks_advance: assert property (@(posedge clk) disable iff (!arst_n)
		hold |-> !advance && !ctl.accum)
		else $error("item processed while bias divider settling");

endmodule

FILE: sim/imubc_checker.sv
`timescale 1ns / 100ps

module imubc_checker #(
	parameter int NUM_SAMPLES = 400
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [imubc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [imubc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                             sample_valid,
	input  logic                             sample_stall,
	input  imubc_pkg::sample_t               sample,
	input  logic                             result_valid,
	input  logic                             result_stall,
	input  imubc_pkg::result_t               result,
	output int                               fail_count,
	output int                               pending,
	output int                               results_seen,
	output int                               corrected_seen,
	output int                               saturated_seen
);
	import imubc_pkg::*;

	// thresholds kept unsquared, compared against squared magnitude below
	longint  min_mag;
	longint  max_mag;
	longint  grav;
	bit      cal_done;
	int      still_cnt;
	longint  accel_sum[3];
	longint  rate_sum[3];
	longint  accel_bias[3];
	longint  rate_bias[3];
	result_t due_results[$];
	result_t want;

	function automatic logic signed [15:0] clip16(input longint v);
		if (v > 32767) begin
			saturated_seen++;
			return 16'sh7fff;
		end
		if (v < -32768) begin
			saturated_seen++;
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic result_t correct_sample(input sample_t s);
		longint  a[3];
		longint  r[3];
		longint  mag2;
		result_t res;
		int      i;
		a[0] = s.accel_x;
		a[1] = s.accel_y;
		a[2] = s.accel_z;
		r[0] = s.rate_x;
		r[1] = s.rate_y;
		r[2] = s.rate_z;
		if (!cal_done) begin
			mag2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
			if (mag2 >= min_mag * min_mag && mag2 <= max_mag * max_mag) begin
				if (still_cnt < NUM_SAMPLES) begin
					for (i = 0; i < 3; i++) begin
						accel_sum[i] += a[i];
						rate_sum[i] += r[i];
					end
					still_cnt++;
				end else begin
					// this still item fixes the biases but still leaves raw
					for (i = 0; i < 3; i++) begin
						accel_bias[i] = accel_sum[i] / NUM_SAMPLES;
						rate_bias[i] = rate_sum[i] / NUM_SAMPLES;
					end
					accel_bias[2] -= grav;
					cal_done = 1'b1;
				end
			end
			res.out_accel_x = s.accel_x;
			res.out_accel_y = s.accel_y;
			res.out_accel_z = s.accel_z;
			res.out_rate_x = s.rate_x;
			res.out_rate_y = s.rate_y;
			res.out_rate_z = s.rate_z;
			res.corrected = 1'b0;
		end else begin
			res.out_accel_x = clip16(a[0] - accel_bias[0]);
			res.out_accel_y = clip16(a[1] - accel_bias[1]);
			res.out_accel_z = clip16(a[2] - accel_bias[2]);
			res.out_rate_x = clip16(r[0] - rate_bias[0]);
			res.out_rate_y = clip16(r[1] - rate_bias[1]);
			res.out_rate_z = clip16(r[2] - rate_bias[2]);
			res.corrected = 1'b1;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mag = STILL_MIN_RST;
			max_mag = STILL_MAX_RST;
			grav = GRAVITY_RST;
			cal_done = 1'b0;
			still_cnt = 0;
			for (int i = 0; i < 3; i++) begin
				accel_sum[i] = 0;
				rate_sum[i] = 0;
				accel_bias[i] = 0;
				rate_bias[i] = 0;
			end
			due_results.delete();
			fail_count = 0;
			results_seen = 0;
			corrected_seen = 0;
			saturated_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_STILL_MIN: min_mag = cfg_wdata;
					REG_STILL_MAX: max_mag = cfg_wdata;
					REG_GRAVITY: grav = cfg_wdata[14:0];
					default: ;
				endcase
			end
			if (sample_valid && !sample_stall)
				due_results.push_back(correct_sample(sample));
			if (result_valid && !result_stall) begin
				results_seen++;
				if (result.corrected)
					corrected_seen++;
				if (due_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result item %0d arrived with nothing due", results_seen);
				end else begin
					want = due_results.pop_front();
					if (result.out_accel_x !== want.out_accel_x
							|| result.out_accel_y !== want.out_accel_y
							|| result.out_accel_z !== want.out_accel_z
							|| result.out_rate_x !== want.out_rate_x
							|| result.out_rate_y !== want.out_rate_y
							|| result.out_rate_z !== want.out_rate_z
							|| result.corrected !== want.corrected) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("result item %0d mismatch", results_seen);
							$display("  expected accel %0d %0d %0d rate %0d %0d %0d corrected %0b",
								want.out_accel_x, want.out_accel_y, want.out_accel_z,
								want.out_rate_x, want.out_rate_y, want.out_rate_z,
								want.corrected);
							$display("  actual   accel %0d %0d %0d rate %0d %0d %0d corrected %0b",
								result.out_accel_x, result.out_accel_y, result.out_accel_z,
								result.out_rate_x, result.out_rate_y, result.out_rate_z,
								result.corrected);
						end
					end
				end
			end
		end
		pending = due_results.size();
	end

endmodule

FILE: sim/tb_imu_bias_calibration_core.sv
`timescale 1ns / 100ps

module tb_imu_bias_calibration_core;
	import imubc_pkg::*;

	localparam int NUM_SAMPLES = 400;
	localparam int PHASES = 7;
	localparam int PHASE_ITEMS = 200;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT = 4000;
	localparam int LAT_PAUSE = 4;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef enum {GEN_LEVEL, GEN_OFFSET, GEN_WILD, GEN_MIX} gen_mode_e;
	typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  sample_valid;
	logic                  sample_stall;
	sample_t               sample;
	logic                  result_valid;
	logic                  result_stall;
	result_t               result;

	int       n_fail;
	int       n_pending;
	int       n_results;
	int       n_corrected;
	int       n_saturated;
	int       n_sent;
	int       idle_cycles = 0;
	int       burst_left;
	int       gap_max;
	bit       hold_req;
	int       hold_left;
	rx_mode_e rx_mode;
	int       rx_left;
	int       rx_tick;
	int       accel_off[3];
	int       rate_off[3];

	imu_bias_calibration_core #(.NUM_SAMPLES(NUM_SAMPLES)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	imubc_checker #(.NUM_SAMPLES(NUM_SAMPLES)) u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample         (sample),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result),
		.fail_count     (n_fail),
		.pending        (n_pending),
		.results_seen   (n_results),
		.corrected_seen (n_corrected),
		.saturated_seen (n_saturated)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic signed [15:0] clamp16(input int v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic int jitter(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic signed [15:0] wild16();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic sample_t pack_sample(input int ax, ay, az, rx, ry, rz);
		sample_t s;
		s.accel_x = clamp16(ax);
		s.accel_y = clamp16(ay);
		s.accel_z = clamp16(az);
		s.rate_x = clamp16(rx);
		s.rate_y = clamp16(ry);
		s.rate_z = clamp16(rz);
		return s;
	endfunction

	function automatic sample_t wild_sample();
		sample_t s;
		s.accel_x = wild16();
		s.accel_y = wild16();
		s.accel_z = wild16();
		s.rate_x = wild16();
		s.rate_y = wild16();
		s.rate_z = wild16();
		return s;
	endfunction

	function automatic sample_t draw_sample(input gen_mode_e mode);
		gen_mode_e m;
		m = mode;
		if (m == GEN_MIX)
			m = gen_mode_e'($urandom_range(0, 2));
		case (m)
			// sensor lying flat: magnitude near one g, mostly inside the still window
			GEN_LEVEL: begin
				if ($urandom_range(0, 9) == 0)
					return wild_sample();
				return pack_sample(jitter(1500), jitter(1500), 16384 + jitter(1500),
					jitter(3000), jitter(3000), jitter(3000));
			end
			// large per-axis offsets push the biases far from zero
			GEN_OFFSET: return pack_sample(accel_off[0] + jitter(2048),
				accel_off[1] + jitter(2048), accel_off[2] + jitter(2048),
				rate_off[0] + jitter(2048), rate_off[1] + jitter(2048),
				rate_off[2] + jitter(2048));
			default: return wild_sample();
		endcase
	endfunction

	task automatic offer(input sample_t s);
		int g;
		if (burst_left == 0) begin
			g = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
			if (g > 0) begin
				sample_valid <= 1'b0;
				repeat (g) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (sample_stall);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		while (n_pending != 0)
			@(negedge clk);
		repeat (LAT_PAUSE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// receiver: long hold on request, otherwise a stall pattern that changes by itself
	initial begin
		result_stall = 1'b0;
		hold_left = 0;
		rx_left = 0;
		rx_tick = 0;
		rx_mode = RX_FREE;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				result_stall <= 1'b1;
			end else begin
				if (rx_left == 0) begin
					rx_mode = rx_mode_e'($urandom_range(0, 3));
					rx_left = $urandom_range(64, 256);
				end
				rx_left--;
				rx_tick++;
				case (rx_mode)
					RX_FREE: result_stall <= 1'b0;
					RX_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
					default: result_stall <= ((rx_tick % 7) < 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
				|| cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("no item moved for %0d cycles, %0d results outstanding",
				idle_cycles, n_pending);
			$display("tb_imu_bias_calibration_core NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int        i;
		int        p;
		int        k;
		gen_mode_e mode;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		sample_valid = 1'b0;
		sample = '0;
		hold_req = 1'b0;
		burst_left = 0;
		gap_max = 3;
		n_sent = 0;
		mode = GEN_LEVEL;
		for (i = 0; i < 3; i++) begin
			accel_off[i] = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(16384, 30000));
			rate_off[i] = int'($urandom_range(0, 60000)) - 30000;
		end
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset window: just below and on the low end, on and just above the high end
		offer(pack_sample(0, 0, 0, 0, 0, 0));
		offer(pack_sample(32767, 32767, 32767, 32767, 32767, 32767));
		offer(pack_sample(-32768, -32768, -32768, -32768, -32768, -32768));
		offer(pack_sample(14745, 0, 0, 1, 2, 3));
		offer(pack_sample(14746, 0, 0, 32767, -32768, 0));
		offer(pack_sample(0, -21299, 0, -1, 1, -32768));
		offer(pack_sample(0, 0, 21300, 100, -100, 7));
		offer(pack_sample(0, 0, -21299, -32768, 32767, -1));
		offer(pack_sample(300, -200, 16384, 12, -34, 56));
		drain();

		// minimum above maximum: nothing counts as still
		write_reg(REG_STILL_MIN, 16'hffff);
		write_reg(REG_STILL_MAX, 16'h0000);
		write_reg(REG_SPARE, 16'h1234);
		offer(pack_sample(0, 0, 16384, 5, 5, 5));
		offer(pack_sample(0, 0, 0, 0, 0, 0));
		offer(pack_sample(-32768, -32768, -32768, 32767, 32767, 32767));
		offer(pack_sample(14746, 0, 0, -5, -5, -5));
		drain();

		// widest window: zero magnitude and full scale are both still
		write_reg(REG_STILL_MIN, 16'h0000);
		write_reg(REG_STILL_MAX, 16'hffff);
		offer(pack_sample(0, 0, 0, 0, 0, 0));
		offer(pack_sample(-32768, -32768, -32768, -32768, -32768, -32768));
		offer(pack_sample(32767, 32767, 32767, 32767, 32767, 32767));
		drain();
		write_reg(REG_STILL_MIN, STILL_MIN_RST);
		write_reg(REG_STILL_MAX, STILL_MAX_RST);

		for (p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: begin
					mode = GEN_LEVEL;
				end
				1: begin
					write_reg(REG_STILL_MIN, 16'h0000);
					write_reg(REG_STILL_MAX, 16'hffff);
					write_reg(REG_GRAVITY, 16'($urandom_range(0, 32767)));
					mode = GEN_OFFSET;
				end
				2: begin
					// calibration completes here with an extreme or a random gravity count
					case ($urandom_range(0, 2))
						0: write_reg(REG_GRAVITY, 16'hffff);
						1: write_reg(REG_GRAVITY, 16'h0000);
						default: write_reg(REG_GRAVITY, 16'($urandom));
					endcase
					mode = GEN_WILD;
				end
				3: begin
					write_reg(REG_STILL_MIN, 16'hffff);
					write_reg(REG_STILL_MAX, 16'h0000);
					write_reg(REG_GRAVITY, 16'($urandom));
					mode = GEN_MIX;
				end
				4: begin
					write_reg(REG_STILL_MIN, 16'h0000);
					write_reg(REG_STILL_MAX, 16'hffff);
					write_reg(REG_GRAVITY, 16'h0000);
					mode = GEN_WILD;
				end
				5: begin
					write_reg(REG_STILL_MIN, 16'($urandom));
					write_reg(REG_STILL_MAX, 16'($urandom));
					write_reg(REG_GRAVITY, 16'h7fff);
					mode = GEN_MIX;
				end
				default: begin
					write_reg(REG_STILL_MIN, STILL_MIN_RST);
					write_reg(REG_STILL_MAX, STILL_MAX_RST);
					write_reg(REG_GRAVITY, 16'(GRAVITY_RST));
					mode = GEN_MIX;
				end
			endcase
			gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			// back-to-back items against a receiver that holds off for a long time
			if (p == 3 || p == 5) begin
				hold_req = 1'b1;
				gap_max = 0;
			end
			for (k = 0; k < PHASE_ITEMS; k++)
				offer(draw_sample(mode));
		end
		drain();

		$display("%0d samples sent over directed cases and %0d random phases, %0d results checked",
			n_sent, PHASES, n_results);
		$display("%0d results bias corrected, %0d saturated axis values, %0d mismatches",
			n_corrected, n_saturated, n_fail);
		if (n_pending != 0)
			$display("%0d results never arrived", n_pending);
		if (n_fail == 0 && n_pending == 0) begin
			$display("tb_imu_bias_calibration_core OK");
		end else begin
			$display("tb_imu_bias_calibration_core NOT OK");
		end
		$finish;
	end

endmodule
